### rtl/kmd_pkg.sv
`timescale 1ns / 1ps

package kmd_pkg;

    localparam int ColumnBitsW = 8;
    localparam int RowW        = 3;
    localparam int CountW      = 8;

    localparam logic [CountW-1:0] SettleReset = 8'd5;

    typedef enum logic
    {
        OP_SAMPLE   = 1'b0,
        OP_END_SCAN = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [ColumnBitsW-1:0] stable_row;
        logic                   settling;
        logic                   committed;
    } result_t;

endpackage

### rtl/kmd_if.sv
`timescale 1ns / 1ps

interface kmd_item_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [kmd_pkg::RowW-1:0]            row;
    logic [kmd_pkg::ColumnBitsW-1:0]     column_bits;

    modport source (output valid, output opcode, output row, output column_bits, input ready);
    modport sink   (input valid, input opcode, input row, input column_bits, output ready);
endinterface

interface kmd_result_if;
    logic                                valid;
    logic                                ready;
    logic [kmd_pkg::ColumnBitsW-1:0]     stable_row;
    logic                                settling;
    logic                                committed;

    modport source (output valid, output stable_row, output settling, output committed,
                    input ready);
    modport sink   (input valid, input stable_row, input settling, input committed,
                    output ready);
endinterface

interface kmd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kmd_pkg::CountW-1:0]          data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/kmd_out_buf.sv
`timescale 1ns / 1ps

module kmd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kmd_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output kmd_pkg::result_t  out_data
);
    import kmd_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    push;
    logic    take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign take      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                // push cannot happen while the skid entry is full
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = in_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/key_matrix_debouncer.sv
`timescale 1ns / 1ps
// Key matrix debouncer, ROW_COUNT rows by COLUMN_COUNT columns, one shared
// settle countdown.
// item (sink): opcode 0 stores a row sample (row, column_bits, 1 = pressed);
//   a changed sample reloads the countdown from the settle register.
//   opcode 1 ends a scan pass and decrements a nonzero countdown; when it
//   reaches zero all samples are copied into the debounced matrix.
// result (source): one item per input item, in order: the debounced row
//   named by row (0 for a row beyond the matrix), settling and committed.
// cfg (sink): writes the 8-bit settle count; always ready; write only while
//   the block is idle.
// Output: each result is registered in the result buffer before it is offered.
// Throughput: one item per cycle while item.ready is high; compare, store and
//   the row copy all sit between the accepted item and the result register.
// Stall: a two-entry result buffer takes one more item after the receiver
//   stops; item.ready then stays low until the cycle after a waiting result
//   is taken.
// Reset: samples and debounced rows clear to zero, settle count and
//   countdown load 5, the result buffer empties.
module key_matrix_debouncer
#(
    parameter int ROW_COUNT    = 5,
    parameter int COLUMN_COUNT = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    kmd_cfg_if.sink      cfg,
    kmd_item_if.sink     item,
    kmd_result_if.source result
);
    import kmd_pkg::*;

    localparam int StoreW = (COLUMN_COUNT < ColumnBitsW) ? COLUMN_COUNT : ColumnBitsW;

    typedef logic [ROW_COUNT-1:0][StoreW-1:0] matrix_t;

    matrix_t             sampled_reg;
    matrix_t             sampled_next;
    matrix_t             stable_reg;
    matrix_t             stable_next;
    logic [CountW-1:0]   settle_reg;
    logic [CountW-1:0]   countdown_reg;
    logic [CountW-1:0]   countdown_next;

    logic                accept;
    logic                in_range;
    logic [StoreW-1:0]   bits;
    logic [StoreW-1:0]   sel_sampled;
    logic [StoreW-1:0]   sel_stable;
    logic [ROW_COUNT-1:0] row_hit;
    logic                changed;
    logic                commit;
    result_t             res;
    result_t             out_data;
    logic                buf_ready;
    logic                buf_valid;

    assign cfg.ready  = 1'b1;
    assign item.ready = buf_ready;
    assign accept     = item.valid && buf_ready;
    assign in_range   = int'(item.row) < ROW_COUNT;
    assign bits       = StoreW'(item.column_bits);

    always_comb
    begin
        sel_sampled = '0;
        sel_stable  = '0;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            row_hit[i] = (int'(item.row) == i);
            if (row_hit[i])
            begin
                sel_sampled = sampled_reg[i];
                sel_stable  = stable_reg[i];
            end
        end
    end

    always_comb
    begin
        changed = (item.opcode == OP_SAMPLE) && in_range && (sel_sampled != bits);
        commit  = (item.opcode == OP_END_SCAN) && (countdown_reg == CountW'(1));

        countdown_next = countdown_reg;
        priority if (changed)
            countdown_next = settle_reg;
        else if ((item.opcode == OP_END_SCAN) && (countdown_reg != '0))
            countdown_next = countdown_reg - CountW'(1);
        else
            countdown_next = countdown_reg;

        sampled_next = sampled_reg;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (changed && row_hit[i])
                sampled_next[i] = bits;
        end
        stable_next = commit ? sampled_reg : stable_reg;

        res.stable_row = in_range ? ColumnBitsW'(commit ? sel_sampled : sel_stable)
                                  : '0;
        res.settling   = (countdown_next != '0);
        res.committed  = commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg    <= SettleReset;
            countdown_reg <= SettleReset;
            sampled_reg   <= '0;
            stable_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
                settle_reg <= cfg.data;
            if (accept)
            begin
                countdown_reg <= countdown_next;
                sampled_reg   <= sampled_next;
                stable_reg    <= stable_next;
            end
        end
    end

    kmd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (buf_valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.valid      = buf_valid;
    assign result.stable_row = out_data.stable_row;
    assign result.settling   = out_data.settling;
    assign result.committed  = out_data.committed;

`ifndef SYNTHESIS
    // an idle countdown only restarts on a changed sample
    a_idle_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.opcode == OP_END_SCAN) && (countdown_reg == '0)
        |=> (countdown_reg == '0))
        else $error("countdown left zero on end of scan");

    a_commit_copy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && commit |=> (stable_reg == $past(sampled_reg)))
        else $error("commit did not copy the sampled matrix");

    a_commit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && commit |-> !res.settling && (item.opcode == OP_END_SCAN))
        else $error("commit while still settling");

    // the buffer only backpressures when it holds a waiting result
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !buf_ready |-> buf_valid)
        else $error("item.ready low with no result pending");
`endif

endmodule
